@@ sv/kltmv_pkg.sv @@
// Shared constants and types for the knob level trimmed-mean vote block.
package kltmv_pkg;

    localparam int SAMPLES_PER_GROUP = 5;
    localparam int VOTES             = 3;
    localparam int LEVELS            = 10;

    localparam int SAMPLE_W = 12;
    localparam int LEVEL_W  = 4;
    localparam int CFG_W    = 12;
    localparam int CFG_IDX_W = 1;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_STEP    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_THRESHOLD = 1'd1;

    localparam logic [CFG_W-1:0] LEVEL_STEP_RST    = 12'd277;
    localparam logic [CFG_W-1:0] TOP_THRESHOLD_RST = 12'hFFF;

    localparam logic [LEVEL_W-1:0]  NO_LEVEL   = 4'hF;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

    localparam int CNT_W   = $clog2(SAMPLES_PER_GROUP);
    localparam int SUM_W   = $clog2(SAMPLES_PER_GROUP * (2**SAMPLE_W - 1) + 1);
    localparam int GROUP_DIV = SAMPLES_PER_GROUP - 2;

    // Divide by GROUP_DIV as multiply by ceil(2^RECIP_SHIFT / GROUP_DIV)
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP       = (2**RECIP_SHIFT + GROUP_DIV - 1) / GROUP_DIV;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;

    // Threshold k = step * (k + 1) needs at most this many bits
    localparam int THR_W = CFG_W + $clog2(LEVELS);

    localparam int VIDX_W      = $clog2(VOTES + 1);
    localparam int STORE_DEPTH = (VOTES > 1) ? VOTES - 1 : 1;

    typedef logic [LEVEL_W-1:0] level_t;

endpackage

@@ sv/kltmv_level.sv @@
// Level quantizer: maps a group mean onto the first threshold it falls below.
module kltmv_level (
    input  logic [kltmv_pkg::SAMPLE_W-1:0] mean,
    input  logic [kltmv_pkg::CFG_W-1:0]    level_step,
    input  logic [kltmv_pkg::CFG_W-1:0]    top_threshold,
    output kltmv_pkg::level_t              level
);

    logic [kltmv_pkg::THR_W-1:0]  thr [kltmv_pkg::LEVELS];
    logic [kltmv_pkg::LEVELS-1:0] below;

    always_comb begin
        for (int k = 0; k < kltmv_pkg::LEVELS; k++) begin
            if (k == kltmv_pkg::LEVELS - 1) begin
                thr[k] = kltmv_pkg::THR_W'(top_threshold);
            end else begin
                thr[k] = kltmv_pkg::THR_W'(level_step) * kltmv_pkg::THR_W'(k + 1);
            end
            below[k] = kltmv_pkg::THR_W'(mean) < thr[k];
        end
    end

    // Lowest-index matching threshold wins; thresholds need not be ordered
    always_comb begin
        level = kltmv_pkg::NO_LEVEL;
        for (int k = kltmv_pkg::LEVELS - 1; k >= 0; k--) begin
            if (below[k]) begin
                level = kltmv_pkg::LEVEL_W'(k);
            end
        end
    end

endmodule

@@ sv/knob_level_trimmed_mean_vote_top.sv @@
// Knob level filter: trimmed mean of each five samples, quantized, voted over three groups.
//
// Takes one 12-bit ADC sample per beat and accepts a sample in every cycle while s_tready is
// high. Every five samples form a group whose smallest and largest values are dropped; the
// middle three are averaged with rounding and mapped to a level 0..9, or to no level, against
// thresholds level_step*(k+1) and top_threshold. Every three groups (fifteen samples) one
// result beat comes out: the level if all three groups produced the same level, else level 0
// with agreed low. A group passes through the trimmed-sum register, then the divide-by-three
// multiply register, and then the quantize-and-vote result is loaded into the output register.
// Backpressure on the result side stalls input only when every stage holds a group that
// cannot move. The user must write configuration through cfg_wr_en/cfg_index/cfg_data only
// while no work is pending; the block itself does not enforce this.
module knob_level_trimmed_mean_vote_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [15:0]                       s_tdata,   // [11:0] sample
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // [3:0] level
    output logic                              m_tuser,   // [0] agreed
    input  logic                              cfg_wr_en,
    input  logic [kltmv_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kltmv_pkg::CFG_W-1:0]       cfg_data
);

    // Configuration registers
    logic [kltmv_pkg::CFG_W-1:0] level_step_reg;
    logic [kltmv_pkg::CFG_W-1:0] top_threshold_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_step_reg    <= kltmv_pkg::LEVEL_STEP_RST;
            top_threshold_reg <= kltmv_pkg::TOP_THRESHOLD_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                kltmv_pkg::REG_LEVEL_STEP:    level_step_reg    <= cfg_data;
                kltmv_pkg::REG_TOP_THRESHOLD: top_threshold_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline handshake
    logic out_free;
    logic mean_consume;
    logic mean_load;
    logic grp_load;
    logic in_fire;
    logic grp_valid_reg;
    logic mean_valid_reg;
    logic m_tvalid_reg;

    assign out_free     = !m_tvalid_reg || m_tready;
    assign mean_consume = mean_valid_reg && out_free;
    assign mean_load    = !mean_valid_reg || mean_consume;
    assign s_tready     = !grp_valid_reg || mean_load;
    assign in_fire      = s_tvalid && s_tready;

    // Stage 1: running sum, min and max
    logic [kltmv_pkg::SAMPLE_W-1:0] sample;
    logic [kltmv_pkg::CNT_W-1:0]    cnt_reg;
    logic [kltmv_pkg::SUM_W-1:0]    sum_reg;
    logic [kltmv_pkg::SAMPLE_W-1:0] min_reg;
    logic [kltmv_pkg::SAMPLE_W-1:0] max_reg;
    logic [kltmv_pkg::SUM_W-1:0]    sum_next;
    logic [kltmv_pkg::SAMPLE_W-1:0] min_next;
    logic [kltmv_pkg::SAMPLE_W-1:0] max_next;
    logic [kltmv_pkg::SUM_W-1:0]    trimmed_next;
    logic [kltmv_pkg::SUM_W-1:0]    trimmed_reg;
    logic                           grp_last;

    assign sample       = s_tdata[kltmv_pkg::SAMPLE_W-1:0];
    assign sum_next     = sum_reg + kltmv_pkg::SUM_W'(sample);
    assign min_next     = (sample < min_reg) ? sample : min_reg;
    assign max_next     = (sample > max_reg) ? sample : max_reg;
    assign trimmed_next = sum_next - kltmv_pkg::SUM_W'(min_next)
                        - kltmv_pkg::SUM_W'(max_next);
    assign grp_last     = cnt_reg == kltmv_pkg::CNT_W'(kltmv_pkg::SAMPLES_PER_GROUP - 1);
    assign grp_load     = grp_valid_reg && mean_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            sum_reg       <= '0;
            min_reg       <= kltmv_pkg::SAMPLE_MAX;
            max_reg       <= '0;
            grp_valid_reg <= 1'b0;
        end else begin
            if (in_fire && grp_last) begin
                grp_valid_reg <= 1'b1;
            end else if (grp_load) begin
                grp_valid_reg <= 1'b0;
            end
            if (in_fire) begin
                if (grp_last) begin
                    cnt_reg <= '0;
                    sum_reg <= '0;
                    min_reg <= kltmv_pkg::SAMPLE_MAX;
                    max_reg <= '0;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                    sum_reg <= sum_next;
                    min_reg <= min_next;
                    max_reg <= max_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && grp_last) begin
            trimmed_reg <= trimmed_next;
        end
    end

    // Stage 2: rounded divide by the number of kept samples
    logic [kltmv_pkg::PROD_W-1:0]   prod;
    logic [kltmv_pkg::SAMPLE_W-1:0] mean_reg;

    assign prod = (kltmv_pkg::PROD_W'(trimmed_reg)
                   + kltmv_pkg::PROD_W'(kltmv_pkg::GROUP_DIV / 2))
                * kltmv_pkg::PROD_W'(kltmv_pkg::RECIP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mean_valid_reg <= 1'b0;
        end else if (mean_load) begin
            mean_valid_reg <= grp_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (grp_load) begin
            mean_reg <= kltmv_pkg::SAMPLE_W'(prod >> kltmv_pkg::RECIP_SHIFT);
        end
    end

    // Stage 3: quantize and vote
    kltmv_pkg::level_t                 grp_level;
    kltmv_pkg::level_t                 vote_store_reg [kltmv_pkg::STORE_DEPTH];
    logic [kltmv_pkg::VIDX_W-1:0]      vote_idx_reg;
    logic                              vote_last;
    logic                              vote_ok;
    kltmv_pkg::level_t                 m_level_reg;
    logic                              m_agreed_reg;

    kltmv_level u_level (
        .mean          (mean_reg),
        .level_step    (level_step_reg),
        .top_threshold (top_threshold_reg),
        .level         (grp_level)
    );

    assign vote_last = vote_idx_reg == kltmv_pkg::VIDX_W'(kltmv_pkg::VOTES - 1);

    always_comb begin
        vote_ok = grp_level != kltmv_pkg::NO_LEVEL;
        for (int i = 0; i < kltmv_pkg::VOTES - 1; i++) begin
            if (vote_store_reg[i] != grp_level) begin
                vote_ok = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vote_idx_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (mean_consume && vote_last) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (mean_consume) begin
                if (vote_last) begin
                    vote_idx_reg <= '0;
                end else begin
                    vote_idx_reg <= vote_idx_reg + 1'b1;
                end
            end
        end
    end

    // Hold the earlier group levels of the current vote
    always_ff @(posedge aclk) begin
        for (int i = 0; i < kltmv_pkg::STORE_DEPTH; i++) begin
            if (mean_consume && !vote_last
                && vote_idx_reg == kltmv_pkg::VIDX_W'(i)) begin
                vote_store_reg[i] <= grp_level;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mean_consume && vote_last) begin
            m_level_reg  <= vote_ok ? grp_level : '0;
            m_agreed_reg <= vote_ok;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(8 - kltmv_pkg::LEVEL_W){1'b0}}, m_level_reg};
    assign m_tuser  = m_agreed_reg;

endmodule

@@ test/tb.sv @@
// Testbench for the knob level trimmed-mean vote block: random and directed samples, predicted votes.
`timescale 1ns / 100ps

module tb;
    import kltmv_pkg::*;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int HOLDOFF_LEN   = 300;
    localparam int SETTLE_CYCLES = 10;

    // Idling modes of a phase
    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_RECV = 2;
    localparam int IDLE_BOTH = 3;

    typedef struct packed {
        level_t level;
        logic   agreed;
    } vote_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata   = '0;   // [11:0] sample
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [7:0]           m_tdata;          // [3:0] level
    logic                 m_tuser;          // [0] agreed
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    knob_level_trimmed_mean_vote_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    // Samples waiting to be sent and votes waiting to come out
    logic [SAMPLE_W-1:0] sample_q[$];
    vote_t               vote_q[$];

    // Predictor state and its copy of the registers
    logic [CFG_W-1:0] step_reg = LEVEL_STEP_RST;
    logic [CFG_W-1:0] top_reg  = TOP_THRESHOLD_RST;
    int               grp_cnt  = 0;
    int               grp_sum  = 0;
    int               grp_min  = 4095;
    int               grp_max  = 0;
    int               vote_cnt = 0;
    level_t           vote_lvl[VOTES-1];

    int send_idle    = 0;
    int recv_stall   = 0;
    int holdoff_req  = 0;
    int holdoff_done = 0;
    int holdoff_left = 0;
    int errors       = 0;
    int cycles       = 0;

    function automatic level_t quantize_mean(input int mean);
        int thr;
        for (int k = 0; k < LEVELS; k++) begin
            thr = (k == LEVELS - 1) ? int'(top_reg) : int'(step_reg) * (k + 1);
            if (mean < thr) return level_t'(k);
        end
        return NO_LEVEL;
    endfunction

    task automatic take_sample(input logic [SAMPLE_W-1:0] s);
        int     trimmed;
        int     mean;
        level_t lvl;
        logic   ok;
        vote_t  v;
        grp_sum += int'(s);
        if (int'(s) < grp_min) grp_min = int'(s);
        if (int'(s) > grp_max) grp_max = int'(s);
        grp_cnt++;
        if (grp_cnt == SAMPLES_PER_GROUP) begin
            trimmed = grp_sum - grp_min - grp_max;
            mean    = (trimmed + (SAMPLES_PER_GROUP - 2) / 2) / (SAMPLES_PER_GROUP - 2);
            grp_cnt = 0;
            grp_sum = 0;
            grp_min = 4095;
            grp_max = 0;
            lvl = quantize_mean(mean);
            if (vote_cnt + 1 < VOTES) begin
                vote_lvl[vote_cnt] = lvl;
                vote_cnt++;
            end else begin
                ok = (lvl != NO_LEVEL);
                for (int i = 0; i < VOTES - 1; i++) begin
                    if (vote_lvl[i] != lvl) ok = 1'b0;
                end
                vote_cnt = 0;
                v.level  = ok ? lvl : '0;
                v.agreed = ok;
                vote_q.push_back(v);
            end
        end
    endtask

    // Sender: hold a beat until taken, predict on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                take_sample(s_tdata[SAMPLE_W-1:0]);
                void'(sample_q.pop_front());
            end
            if (!s_tvalid || s_tready) begin
                if (sample_q.size() > 0 && $urandom_range(99) >= send_idle) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {4'b0, sample_q[0]};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each beat against the oldest predicted vote
    always @(posedge aclk) begin
        vote_t exp_v;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (vote_q.size() == 0) begin
                    $display("%0t unexpected beat: expected none, got level %0d agreed %0b",
                             $time, m_tdata[3:0], m_tuser);
                    errors++;
                end else begin
                    exp_v = vote_q.pop_front();
                    if (m_tdata[3:0] !== exp_v.level) begin
                        $display("%0t level mismatch: expected %0d, got %0d",
                                 $time, exp_v.level, m_tdata[3:0]);
                        errors++;
                    end
                    if (m_tuser !== exp_v.agreed) begin
                        $display("%0t agreed mismatch: expected %0b, got %0b",
                                 $time, exp_v.agreed, m_tuser);
                        errors++;
                    end
                end
            end
            if (holdoff_left > 0) begin
                holdoff_left <= holdoff_left - 1;
                m_tready     <= 1'b0;
            end else if (holdoff_req != holdoff_done) begin
                holdoff_left <= HOLDOFF_LEN;
                holdoff_done <= holdoff_done + 1;
                m_tready     <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall);
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("%0t timeout with %0d votes outstanding", $time, vote_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [SAMPLE_W-1:0] clamp_sample(input int v);
        if (v < 0) return '0;
        if (v > 4095) return SAMPLE_MAX;
        return SAMPLE_W'(v);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_LEVEL_STEP) step_reg = val;
        else top_reg = val;
    endtask

    task automatic wait_drain();
        do @(negedge aclk);
        while (sample_q.size() != 0 || s_tvalid || vote_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            IDLE_NONE: begin
                send_idle = 0;  recv_stall = 0;
            end
            IDLE_SEND: begin
                send_idle = 56; recv_stall = 0;
            end
            IDLE_RECV: begin
                send_idle = 0;  recv_stall = 56;
            end
            default: begin
                send_idle = 30; recv_stall = 30;
            end
        endcase
    endtask

    // One vote's worth of samples: mostly steady knob positions, some near a threshold,
    // some with extreme outliers that the trim should drop, and some pure noise
    task automatic push_vote();
        int kind;
        int base;
        int k;
        int lo_pos;
        int hi_pos;
        logic outliers;
        logic [SAMPLE_W-1:0] v;
        kind = $urandom_range(0, 9);
        base = $urandom_range(0, 4095);
        if (kind < 3) begin
            k    = $urandom_range(0, LEVELS - 1);
            base = (k == LEVELS - 1) ? int'(top_reg) : int'(step_reg) * (k + 1);
            base = base + $urandom_range(0, 4) - 2;
        end
        outliers = (kind >= 3 && kind < 6);
        for (int g = 0; g < VOTES; g++) begin
            lo_pos = $urandom_range(0, SAMPLES_PER_GROUP - 1);
            hi_pos = $urandom_range(0, SAMPLES_PER_GROUP - 1);
            for (int i = 0; i < SAMPLES_PER_GROUP; i++) begin
                if (kind >= 8) v = SAMPLE_W'($urandom_range(0, 4095));
                else if (outliers && i == lo_pos) v = '0;
                else if (outliers && i == hi_pos) v = SAMPLE_MAX;
                else v = clamp_sample(base + $urandom_range(0, 4) - 2);
                sample_q.push_back(v);
            end
        end
    endtask

    task automatic run_phase(input int step, input int top, input int mode, input int votes);
        write_reg(REG_LEVEL_STEP, CFG_W'(step));
        write_reg(REG_TOP_THRESHOLD, CFG_W'(top));
        set_idling(mode);
        for (int i = 0; i < votes / 2; i++) push_vote();
        // pause the sender until everything queued has come out
        wait_drain();
        for (int i = votes / 2; i < votes; i++) push_vote();
        wait_drain();
    endtask

    // Directed: all zero, rounding up, equal extremes, full scale, and
    // a group with no level under the reset thresholds
    logic [SAMPLE_W-1:0] directed[30] = '{
        12'd0,    12'd0,    12'd0,    12'd0,    12'd0,
        12'd4095, 12'd0,    12'd1,    12'd1,    12'd0,
        12'd1,    12'd1,    12'd1,    12'd2,    12'd0,
        12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095,
        12'd7,    12'd7,    12'd7,    12'd100,  12'd100,
        12'd4095, 12'd4095, 12'd4094, 12'd0,    12'd0
    };

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        set_idling(IDLE_NONE);
        foreach (directed[i]) sample_q.push_back(directed[i]);
        wait_drain();

        // long receiver hold-off while the sender keeps offering
        for (int i = 0; i < 12; i++) push_vote();
        holdoff_req = holdoff_req + 1;
        wait_drain();

        run_phase(0,    4095, IDLE_SEND, 16);
        run_phase(4095, 0,    IDLE_RECV, 16);
        run_phase(1,    10,   IDLE_BOTH, 16);
        run_phase(500,  100,  IDLE_NONE, 16);   // thresholds out of order
        run_phase($urandom_range(1, 600), $urandom_range(0, 4095), IDLE_SEND, 16);
        run_phase($urandom_range(200, 455), 4095, IDLE_RECV, 16);
        run_phase(277,  4095, IDLE_BOTH, 16);

        if (errors == 0 && vote_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
